// File: design/mml_command_to_midi_events_assert.svh
// ----------------------------------------------------------------------------
// mml_command_to_midi_events assertion macros
// Clocked on clk, held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef MML_COMMAND_TO_MIDI_EVENTS_ASSERT_SVH
`define MML_COMMAND_TO_MIDI_EVENTS_ASSERT_SVH

// Same-cycle implication.
`define MML_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mml2midi assertion failed");

// Next-cycle implication.
`define MML_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mml2midi assertion failed");

`endif

// File: design/mml2midi_pkg.sv
// ----------------------------------------------------------------------------
// mml2midi_pkg
// Types, command codes and event constants shared by the MML-to-MIDI block.
// ----------------------------------------------------------------------------
package mml2midi_pkg;

  localparam int CNT_W  = 3;   // byte index within one event, up to 8 bytes
  localparam int DIVD_W = 25;  // dividend width: 30000000 needs 25 bits
  localparam int DIVR_W = 16;  // divisor width
  localparam int DCNT_W = 5;   // divider step counter

  // Command codes
  localparam logic [3:0] FUNC_NOTE      = 4'd0;
  localparam logic [3:0] FUNC_REST      = 4'd1;
  localparam logic [3:0] FUNC_SET_OCT   = 4'd2;
  localparam logic [3:0] FUNC_OCT_DOWN  = 4'd3;
  localparam logic [3:0] FUNC_OCT_UP    = 4'd4;
  localparam logic [3:0] FUNC_TRANSPOSE = 4'd5;
  localparam logic [3:0] FUNC_VOLUME    = 4'd6;
  localparam logic [3:0] FUNC_TEMPO     = 4'd7;
  localparam logic [3:0] FUNC_INSTR     = 4'd8;
  localparam logic [3:0] FUNC_END       = 4'd9;

  // Index of the final byte of each event
  localparam logic [CNT_W-1:0] LAST_NOTE  = 3'd7;
  localparam logic [CNT_W-1:0] LAST_TEMPO = 3'd6;
  localparam logic [CNT_W-1:0] LAST_INSTR = 3'd2;
  localparam logic [CNT_W-1:0] LAST_END   = 3'd3;

  // MIDI bytes
  localparam logic [7:0] EV_NOTE_ON     = 8'h90;
  localparam logic [7:0] EV_NOTE_OFF    = 8'h80;
  localparam logic [7:0] EV_PROGRAM     = 8'hC0;
  localparam logic [7:0] EV_META        = 8'hFF;
  localparam logic [7:0] META_TEMPO     = 8'h51;
  localparam logic [7:0] META_TEMPO_LEN = 8'h03;
  localparam logic [7:0] META_EOT       = 8'h2F;

  localparam logic [7:0] OCT_RESET = 8'd4;
  localparam logic [7:0] OCT_MAX   = 8'd9;
  localparam logic [7:0] VEL_RESET = 8'h7F;

  localparam logic [DIVD_W-1:0] TEMPO_NUM = 25'd30000000;

  // Volume scaling: 127 = 14 * 9 + 1, and m/9 = (m * ceil(2^19 / 9)) >> 19
  // for any 16-bit magnitude m.
  localparam logic [7:0]  VOL_WHOLE  = 8'd14;
  localparam logic [15:0] VOL_RECIP9 = 16'd58255;
  localparam int          VOL_SHIFT  = 19;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic upd;
    logic div_start;
    logic vol_wr;
    logic emit_adv;
    logic cnt_clr;
  } ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic [3:0] func;
    logic       bad;
    logic       div_busy;
    logic       last;
  } stat_t;

  function automatic logic [7:0] letter_base(input logic [2:0] l);
    logic [7:0] v;
    case (l)
      3'd0:    v = 8'd21;
      3'd1:    v = 8'd23;
      3'd2:    v = 8'd12;
      3'd3:    v = 8'd14;
      3'd4:    v = 8'd16;
      3'd5:    v = 8'd17;
      3'd6:    v = 8'd19;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [7:0] dur_value(input logic [3:0] i);
    logic [7:0] v;
    case (i)
      4'd0:    v = 8'd1;
      4'd1:    v = 8'd2;
      4'd2:    v = 8'd3;
      4'd3:    v = 8'd4;
      4'd4:    v = 8'd6;
      4'd5:    v = 8'd8;
      4'd6:    v = 8'd12;
      4'd7:    v = 8'd16;
      4'd8:    v = 8'd24;
      4'd9:    v = 8'd32;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/mml2midi_cmd_if.sv
// ----------------------------------------------------------------------------
// mml2midi_cmd_if
// Command channel: one parsed music-macro command per item.
// ----------------------------------------------------------------------------
interface mml2midi_cmd_if;
  logic              valid;
  logic              ready;
  logic [3:0]        func;
  logic [2:0]        note_letter;
  logic signed [3:0] accidental;
  logic signed [15:0] amount;

  modport source (output valid, func, note_letter, accidental, amount, input ready);
  modport sink (input valid, func, note_letter, accidental, amount, output ready);
endinterface

// File: design/mml2midi_byte_if.sv
// ----------------------------------------------------------------------------
// mml2midi_byte_if
// Event byte channel: one MIDI track byte per item.
// ----------------------------------------------------------------------------
interface mml2midi_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;
  logic       bad_command;

  modport source (output valid, out_byte, last, bad_command, input ready);
  modport sink (input valid, out_byte, last, bad_command, output ready);
endinterface

// File: design/mml2midi_div.sv
// ----------------------------------------------------------------------------
// mml2midi_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mml2midi_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [mml2midi_pkg::DIVD_W-1:0]   dividend,
  input  logic [mml2midi_pkg::DIVR_W-1:0]   divisor,
  output logic                              busy,
  output logic [mml2midi_pkg::DIVD_W-1:0]   quotient
);

  logic [mml2midi_pkg::DIVR_W:0]     rem;
  logic [mml2midi_pkg::DIVR_W:0]     rem_sh;
  logic [mml2midi_pkg::DIVR_W:0]     rem_next;
  logic [mml2midi_pkg::DIVR_W-1:0]   divr;
  logic [mml2midi_pkg::DIVD_W-1:0]   dq;
  logic [mml2midi_pkg::DCNT_W-1:0]   step;
  logic                              fits;

  always_comb begin
    rem_sh   = {rem[mml2midi_pkg::DIVR_W-1:0], dq[mml2midi_pkg::DIVD_W-1]};
    fits     = (rem_sh >= {1'b0, divr});
    rem_next = fits ? (rem_sh - {1'b0, divr}) : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      step <= step + 1'b1;
      if (step == mml2midi_pkg::DCNT_W'(mml2midi_pkg::DIVD_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Dividend bits shift out the top while quotient bits shift in the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      dq   <= dividend;
      divr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dq  <= {dq[mml2midi_pkg::DIVD_W-2:0], fits};
    end
  end

  assign quotient = dq;

endmodule

// File: design/mml2midi_dp.sv
// ----------------------------------------------------------------------------
// mml2midi_dp
// Datapath: command latch, octave/velocity/transpose registers, divider,
// event byte selection.
// ----------------------------------------------------------------------------
module mml2midi_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  mml2midi_pkg::ctl_t         ctl,
  input  logic [3:0]                 func_in,
  input  logic [2:0]                 letter_in,
  input  logic signed [3:0]          acc_in,
  input  logic signed [15:0]         amount_in,
  output mml2midi_pkg::stat_t        st,
  output logic [7:0]                 out_byte,
  output logic                       last,
  output logic                       bad_command
);

  logic [3:0]                        func;
  logic [2:0]                        letter;
  logic signed [3:0]                 acc;
  logic signed [15:0]                amount;
  logic [15:0]                       vol_mag;
  logic [31:0]                       vol_prod;
  logic [7:0]                        vol_sum;
  logic [7:0]                        octave;
  logic [7:0]                        velocity;
  logic [7:0]                        transpose;
  logic [mml2midi_pkg::CNT_W-1:0]    cnt;

  logic [mml2midi_pkg::DIVD_W-1:0]   dividend;
  logic [mml2midi_pkg::DIVR_W-1:0]   divisor;
  logic [mml2midi_pkg::DIVD_W-1:0]   quotient;
  logic                              div_busy;
  logic                              bad;
  logic [7:0]                        oct12;
  logic [7:0]                        note_num;
  logic [7:0]                        n_byte;
  logic [7:0]                        v_byte;
  logic [mml2midi_pkg::CNT_W-1:0]    last_idx;
  logic [7:0]                        sel_byte;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      func    <= func_in;
      letter  <= letter_in;
      acc     <= acc_in;
      amount  <= amount_in;
      vol_mag <= amount_in[15] ? (16'd0 - amount_in) : amount_in;
    end
  end

  // m/9 by reciprocal multiply; ready in the cycle after the command latch.
  always_ff @(posedge clk) begin
    vol_prod <= {16'd0, vol_mag} * {16'd0, mml2midi_pkg::VOL_RECIP9};
  end

  // 127*m/9 = 14*m + m/9; only the low byte is kept.
  always_comb begin
    vol_sum = vol_mag[7:0] * mml2midi_pkg::VOL_WHOLE
            + vol_prod[mml2midi_pkg::VOL_SHIFT +: 8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      octave    <= mml2midi_pkg::OCT_RESET;
      velocity  <= mml2midi_pkg::VEL_RESET;
      transpose <= '0;
    end else begin
      if (ctl.upd) begin
        case (func)
          mml2midi_pkg::FUNC_SET_OCT:   octave <= amount[7:0];
          mml2midi_pkg::FUNC_OCT_DOWN:  if (octave != 8'd0) octave <= octave - 8'd1;
          mml2midi_pkg::FUNC_OCT_UP: begin
            if (octave != mml2midi_pkg::OCT_MAX) octave <= octave + 8'd1;
          end
          mml2midi_pkg::FUNC_TRANSPOSE: transpose <= amount[7:0];
          default: ;
        endcase
      end
      // Truncate toward zero: divide the magnitude, restore the sign.
      if (ctl.vol_wr) begin
        velocity <= amount[15] ? (8'd0 - vol_sum) : vol_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.cnt_clr) begin
      cnt <= '0;
    end else if (ctl.emit_adv) begin
      cnt <= cnt + 1'b1;
    end
  end

  assign dividend = mml2midi_pkg::TEMPO_NUM;
  assign divisor  = amount;

  mml2midi_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  always_comb begin
    case (func)
      mml2midi_pkg::FUNC_NOTE,
      mml2midi_pkg::FUNC_REST:  bad = amount[15] || (amount > 16'sd9);
      mml2midi_pkg::FUNC_TEMPO: bad = amount[15] || (amount == 16'sd0);
      default:                  bad = 1'b0;
    endcase
  end

  always_comb begin
    oct12    = {octave[4:0], 3'b000} + {octave[5:0], 2'b00};
    note_num = mml2midi_pkg::letter_base(letter) + oct12 + {{4{acc[3]}}, acc} + transpose;
    n_byte   = (func == mml2midi_pkg::FUNC_NOTE) ? note_num : 8'd0;
    v_byte   = (func == mml2midi_pkg::FUNC_NOTE) ? velocity : 8'd0;
  end

  always_comb begin
    sel_byte = 8'd0;
    last_idx = '0;
    case (func)
      mml2midi_pkg::FUNC_NOTE,
      mml2midi_pkg::FUNC_REST: begin
        last_idx = mml2midi_pkg::LAST_NOTE;
        case (cnt)
          3'd1:    sel_byte = mml2midi_pkg::EV_NOTE_ON;
          3'd2:    sel_byte = n_byte;
          3'd3:    sel_byte = v_byte;
          3'd4:    sel_byte = mml2midi_pkg::dur_value(amount[3:0]);
          3'd5:    sel_byte = mml2midi_pkg::EV_NOTE_OFF;
          3'd6:    sel_byte = n_byte;
          3'd7:    sel_byte = v_byte;
          default: sel_byte = 8'd0;
        endcase
      end
      mml2midi_pkg::FUNC_TEMPO: begin
        last_idx = mml2midi_pkg::LAST_TEMPO;
        case (cnt)
          3'd1:    sel_byte = mml2midi_pkg::EV_META;
          3'd2:    sel_byte = mml2midi_pkg::META_TEMPO;
          3'd3:    sel_byte = mml2midi_pkg::META_TEMPO_LEN;
          3'd4:    sel_byte = quotient[23:16];
          3'd5:    sel_byte = quotient[15:8];
          3'd6:    sel_byte = quotient[7:0];
          default: sel_byte = 8'd0;
        endcase
      end
      mml2midi_pkg::FUNC_INSTR: begin
        last_idx = mml2midi_pkg::LAST_INSTR;
        case (cnt)
          3'd1:    sel_byte = mml2midi_pkg::EV_PROGRAM;
          3'd2:    sel_byte = amount[7:0];
          default: sel_byte = 8'd0;
        endcase
      end
      mml2midi_pkg::FUNC_END: begin
        last_idx = mml2midi_pkg::LAST_END;
        case (cnt)
          3'd1:    sel_byte = mml2midi_pkg::EV_META;
          3'd2:    sel_byte = mml2midi_pkg::META_EOT;
          default: sel_byte = 8'd0;
        endcase
      end
      default: ;
    endcase
  end

  // A rejected command yields one zero byte flagged bad.
  assign out_byte    = bad ? 8'd0 : sel_byte;
  assign last        = bad || (cnt == last_idx);
  assign bad_command = bad;

  assign st.func     = func;
  assign st.bad      = bad;
  assign st.div_busy = div_busy;
  assign st.last     = last;

endmodule

// File: design/mml2midi_ctrl.sv
// ----------------------------------------------------------------------------
// mml2midi_ctrl
// Controller: sequences accept, decode, divide and byte emission.
// ----------------------------------------------------------------------------
module mml2midi_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  output logic                 evt_valid,
  input  logic                 evt_ready,
  input  mml2midi_pkg::stat_t  st,
  output mml2midi_pkg::ctl_t   ctl
);

  mml2midi_pkg::state_t state;
  mml2midi_pkg::state_t state_next;
  logic                 uses_div;
  logic                 emits;

  always_comb begin
    uses_div = (st.func == mml2midi_pkg::FUNC_TEMPO) || (st.func == mml2midi_pkg::FUNC_VOLUME);
    emits    = (st.func == mml2midi_pkg::FUNC_NOTE) || (st.func == mml2midi_pkg::FUNC_REST) ||
               (st.func == mml2midi_pkg::FUNC_INSTR) || (st.func == mml2midi_pkg::FUNC_END);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mml2midi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mml2midi_pkg::ST_IDLE: begin
        if (cmd_valid) state_next = mml2midi_pkg::ST_DECODE;
      end
      mml2midi_pkg::ST_DECODE: begin
        if (st.bad || emits) begin
          state_next = mml2midi_pkg::ST_EMIT;
        end else if (uses_div) begin
          state_next = mml2midi_pkg::ST_DIV;
        end else begin
          state_next = mml2midi_pkg::ST_IDLE;
        end
      end
      mml2midi_pkg::ST_DIV: begin
        if (!st.div_busy) begin
          state_next = (st.func == mml2midi_pkg::FUNC_VOLUME) ? mml2midi_pkg::ST_IDLE
                                                              : mml2midi_pkg::ST_EMIT;
        end
      end
      mml2midi_pkg::ST_EMIT: begin
        if (evt_ready && st.last) state_next = mml2midi_pkg::ST_IDLE;
      end
      default: state_next = mml2midi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    evt_valid = 1'b0;
    ctl       = '0;
    unique case (state)
      mml2midi_pkg::ST_IDLE: begin
        cmd_ready = 1'b1;
        ctl.load  = cmd_valid;
      end
      mml2midi_pkg::ST_DECODE: begin
        ctl.upd       = !st.bad;
        // Only tempo divides; volume waits in ST_DIV for its registered product.
        ctl.div_start = !st.bad && (st.func == mml2midi_pkg::FUNC_TEMPO);
        ctl.cnt_clr   = 1'b1;
      end
      mml2midi_pkg::ST_DIV: begin
        ctl.vol_wr = !st.div_busy && (st.func == mml2midi_pkg::FUNC_VOLUME);
      end
      mml2midi_pkg::ST_EMIT: begin
        evt_valid    = 1'b1;
        ctl.emit_adv = evt_ready;
      end
      default: ;
    endcase
  end

endmodule

// File: design/mml_command_to_midi_events.sv
// ----------------------------------------------------------------------------
// mml_command_to_midi_events: music-macro command to MIDI track bytes
// One item at a time: an accept state and a decode state, then one byte
// per cycle while evt.ready is high. Note/rest, instrument, end and tempo
// emit bytes; volume and other valid commands only update registers. Tempo
// first runs the 25-step radix-2 divider. Sync reset: idle, octave 4,
// velocity 127, transpose 0.
// ----------------------------------------------------------------------------
`include "mml_command_to_midi_events_assert.svh"

module mml_command_to_midi_events (
  input  logic                   clk,
  input  logic                   rst,
  mml2midi_cmd_if.sink           cmd,
  mml2midi_byte_if.source        evt
);

  mml2midi_pkg::ctl_t  ctl;
  mml2midi_pkg::stat_t st;

  mml2midi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .st        (st),
    .ctl       (ctl)
  );

  mml2midi_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .func_in     (cmd.func),
    .letter_in   (cmd.note_letter),
    .acc_in      (cmd.accidental),
    .amount_in   (cmd.amount),
    .st          (st),
    .out_byte    (evt.out_byte),
    .last        (evt.last),
    .bad_command (evt.bad_command)
  );

  `MML_ASSERT_IMP(a_ready_excl_valid, cmd.ready, !evt.valid)
  `MML_ASSERT_NEXT(a_one_in_flight, cmd.valid && cmd.ready, !cmd.ready)
  `MML_ASSERT_IMP(a_bad_single, evt.valid && evt.bad_command, evt.last && (evt.out_byte == 8'd0))
  `MML_ASSERT_NEXT(a_div_runs, ctl.div_start, st.div_busy)

endmodule
